// ===== sv/rspp_pkg.sv =====
// ----------------------------------------------------------------------------
// rspp_pkg: shared types, constants and helpers of the road segment projector
// Register indexes, reset values, datapath widths, controller/datapath
// command and status structs, and small saturation helpers.
// ----------------------------------------------------------------------------
package rspp_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_CAMERA_DEPTH  = 2'd0;
  localparam logic [1:0] CFG_ROAD_WIDTH    = 2'd1;
  localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd3;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // configuration reset values
  localparam logic [15:0] CAMERA_DEPTH_RST  = 16'd55050;
  localparam logic [15:0] ROAD_WIDTH_RST    = 16'd2000;
  localparam logic [11:0] SCREEN_WIDTH_RST  = 12'd1024;
  localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd768;

  // datapath widths
  localparam int NUM_W   = 58;   // signed numerator of a projection
  localparam int SHIFT_W = 17;   // denominator is depth << SHIFT_W
  localparam int QBITS   = 17;   // quotient bits kept before saturation
  localparam int DEN_W   = 21;   // positive depth
  localparam int DEPTH_W = 23;   // signed depth difference

  // reciprocal constants: x/5 for 16 bit x, n/3 for 12 bit n
  localparam logic [15:0] RECIP5       = 16'd52429;
  localparam int          RECIP5_SHIFT = 18;
  localparam logic [12:0] RECIP3       = 13'd5462;
  localparam int          RECIP3_SHIFT = 14;

  typedef struct packed {
    logic        first_of_frame;
    logic [11:0] seg_number;
    logic [19:0] seg_z;
    logic [15:0] seg_y;
    logic [15:0] seg_curve;
    logic [23:0] cam_x;
    logic [15:0] cam_y;
    logic [20:0] cam_z;
  } in_item_t;

  typedef struct packed {
    logic        draw;
    logic        stripe;
    logic [15:0] near_y;
    logic [15:0] near_x;
    logic [15:0] near_half_width;
    logic [15:0] near_rumble_width;
    logic [15:0] far_y;
    logic [15:0] far_x;
    logic [15:0] far_half_width;
    logic [15:0] far_rumble_width;
  } out_item_t;

  typedef struct packed {
    logic load;   // capture the input beat
    logic mul1;   // first products, curve update
    logic mul2;   // numerators
    logic prep;   // magnitudes, divider setup
    logic step;   // one quotient bit
    logic fin;    // saturate, horizon test, load output register
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

  // trunc(w*6/5) = w + floor(w/5), saturated to 16 bit
  function automatic logic [15:0] rumble_width(input logic [15:0] w);
    logic [31:0] p;
    logic [16:0] s;
    p = 32'(w) * 32'(RECIP5);
    s = 17'(w) + 17'(p[31:RECIP5_SHIFT]);
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // sign and magnitude to signed 16 bit, saturated
  function automatic logic [15:0] sat_s16(input logic neg, input logic [QBITS-1:0] mag);
    logic [15:0] r;
    if (neg) begin
      if (mag > QBITS'(32768)) r = 16'h8000;
      else r = 16'(~mag[15:0] + 16'd1);
    end else begin
      if (mag > QBITS'(32767)) r = 16'h7FFF;
      else r = mag[15:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/rspp_if.sv =====
// ----------------------------------------------------------------------------
// rspp_if: segment and trapezoid channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rspp_in_if;
  logic        valid;
  logic        ready;
  logic        first_of_frame;
  logic [11:0] seg_number;
  logic [19:0] seg_z;
  logic [15:0] seg_y;
  logic [15:0] seg_curve;
  logic [23:0] cam_x;
  logic [15:0] cam_y;
  logic [20:0] cam_z;

  modport source (output valid, first_of_frame, seg_number, seg_z, seg_y, seg_curve,
                  cam_x, cam_y, cam_z, input ready);
  modport sink (input valid, first_of_frame, seg_number, seg_z, seg_y, seg_curve,
                cam_x, cam_y, cam_z, output ready);
endinterface

interface rspp_out_if;
  logic        valid;
  logic        ready;
  logic        draw;
  logic        stripe;
  logic [15:0] near_y;
  logic [15:0] near_x;
  logic [15:0] near_half_width;
  logic [15:0] near_rumble_width;
  logic [15:0] far_y;
  logic [15:0] far_x;
  logic [15:0] far_half_width;
  logic [15:0] far_rumble_width;

  modport source (output valid, draw, stripe, near_y, near_x, near_half_width,
                  near_rumble_width, far_y, far_x, far_half_width, far_rumble_width,
                  input ready);
  modport sink (input valid, draw, stripe, near_y, near_x, near_half_width,
                near_rumble_width, far_y, far_x, far_half_width, far_rumble_width,
                output ready);
endinterface

// ===== sv/rspp_div_lane.sv =====
// ----------------------------------------------------------------------------
// rspp_div_lane: one lane of the projection divider
// Computes floor(|num| / (den << SHIFT_W)) one bit per step, restoring form,
// saturated to QBITS bits, and the sign of num.
// ----------------------------------------------------------------------------
module rspp_div_lane (
  input  logic                                clk,
  input  logic                                prep,
  input  logic                                step,
  input  logic signed [rspp_pkg::NUM_W-1:0]   num,
  input  logic        [rspp_pkg::DEN_W-1:0]   den,
  output logic                                neg,
  output logic        [rspp_pkg::QBITS-1:0]   mag
);

  localparam int A_W = rspp_pkg::NUM_W - rspp_pkg::SHIFT_W;
  localparam int H_W = A_W - rspp_pkg::QBITS;

  logic [rspp_pkg::NUM_W-1:0] abs_num;
  logic [A_W-1:0]             a;
  logic                       ovf;
  logic [rspp_pkg::DEN_W:0]   trial;
  logic                       fits;

  logic                       neg_r;
  logic                       ovf_r;
  logic [rspp_pkg::DEN_W-1:0] rem_r;
  logic [rspp_pkg::QBITS-1:0] sh_r;
  logic [rspp_pkg::QBITS-1:0] q_r;

  always_comb begin
    abs_num = num[rspp_pkg::NUM_W-1] ? rspp_pkg::NUM_W'(-num) : rspp_pkg::NUM_W'(num);
    a       = abs_num[rspp_pkg::NUM_W-1:rspp_pkg::SHIFT_W];
    // quotient would need more than QBITS bits
    ovf     = a[A_W-1:rspp_pkg::QBITS] >= H_W'(den);
    trial   = {rem_r, sh_r[rspp_pkg::QBITS-1]};
    fits    = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (prep) begin
      neg_r <= num[rspp_pkg::NUM_W-1];
      ovf_r <= ovf;
      rem_r <= a[rspp_pkg::QBITS+rspp_pkg::DEN_W-1:rspp_pkg::QBITS];
      sh_r  <= a[rspp_pkg::QBITS-1:0];
      q_r   <= '0;
    end else if (step) begin
      rem_r <= fits ? rspp_pkg::DEN_W'(trial - {1'b0, den}) : trial[rspp_pkg::DEN_W-1:0];
      sh_r  <= {sh_r[rspp_pkg::QBITS-2:0], 1'b0};
      q_r   <= {q_r[rspp_pkg::QBITS-2:0], fits};
    end
  end

  assign neg = neg_r;
  assign mag = ovf_r ? '1 : q_r;

endmodule

// ===== sv/rspp_datapath.sv =====
// ----------------------------------------------------------------------------
// rspp_datapath: projection datapath
// Configuration and frame state, product and numerator registers, three
// divider lanes (X, Y, half-width), horizon test and the output register.
// ----------------------------------------------------------------------------
module rspp_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [rspp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [rspp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  rspp_pkg::in_item_t                   in_item,
  input  rspp_pkg::dp_cmd_t                    cmd,
  output rspp_pkg::dp_sts_t                    sts,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output rspp_pkg::out_item_t                  out_item
);

  localparam int IN_W = 44;   // inner sum before the screen scale
  localparam int MX_W = 57;   // scaled numerator

  // configuration
  logic [15:0] cam_depth_r, road_width_r;
  logic [11:0] screen_w_r, screen_h_r;

  // frame state
  logic signed [31:0] curve_off_r;
  logic signed [23:0] curve_slope_r;
  logic signed [15:0] horizon_r;
  logic [15:0]        last_x_r, last_y_r, last_hw_r;

  // item registers
  rspp_pkg::in_item_t                      in_r;
  logic signed [rspp_pkg::DEPTH_W-1:0]     d_r;
  logic signed [42:0]                      p_lat_r;
  logic signed [33:0]                      p_h_r;
  logic [31:0]                             p_rw_r;
  logic                                    stripe_r;
  logic signed [rspp_pkg::NUM_W-1:0]       num_x_r, num_y_r, num_w_r;

  logic                                    out_valid_r;
  rspp_pkg::out_item_t                     out_r;
  rspp_pkg::out_item_t                     out_nxt;

  // first products
  logic signed [31:0] cur_off;
  logic signed [23:0] cur_slope;
  logic signed [32:0] t_lat, t_rnd;
  logic signed [24:0] q_lat;
  logic signed [25:0] lat;
  logic signed [16:0] h_diff;
  logic signed [42:0] p_lat;
  logic signed [33:0] p_h;
  logic signed [32:0] off_sum;
  logic signed [24:0] slope_sum;
  logic signed [31:0] off_nxt;
  logic signed [23:0] slope_nxt;
  logic [24:0]        n_prod;

  // numerators
  logic signed [IN_W-1:0] d_sh, inner_x, inner_y;
  logic signed [MX_W-1:0] mx, my;
  logic [43:0]            mw;

  // divider results and final line
  logic                        neg_x, neg_y, neg_w;
  logic [rspp_pkg::QBITS-1:0]  mag_x, mag_y, mag_w;
  logic                        d_pos;
  logic [15:0]                 x_fin, y_fin, w_fin;
  logic                        draw;

  always_comb begin
    cur_off   = in_r.first_of_frame ? 32'sd0 : curve_off_r;
    cur_slope = in_r.first_of_frame ? 24'sd0 : curve_slope_r;
    // trunc((cam_x*256 - offset) / 256), negated
    t_lat     = $signed({in_r.cam_x[23], in_r.cam_x, 8'h00}) - 33'(cur_off);
    t_rnd     = t_lat + (t_lat[32] ? 33'sd255 : 33'sd0);
    q_lat     = t_rnd[32:8];
    lat       = 26'sd0 - 26'(q_lat);
    h_diff    = 17'($signed(in_r.seg_y)) - 17'($signed(in_r.cam_y));
    p_lat     = $signed({1'b0, cam_depth_r}) * lat;
    p_h       = $signed({1'b0, cam_depth_r}) * h_diff;
    off_sum   = 33'(cur_off) + 33'(cur_slope);
    slope_sum = 25'(cur_slope) + 25'($signed(in_r.seg_curve));
    if (off_sum[32] != off_sum[31]) off_nxt = off_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    else off_nxt = off_sum[31:0];
    if (slope_sum[24] != slope_sum[23]) slope_nxt = slope_sum[24] ? 24'sh800000 : 24'sh7FFFFF;
    else slope_nxt = slope_sum[23:0];
    n_prod    = 25'(in_r.seg_number) * 25'(rspp_pkg::RECIP3);
  end

  always_comb begin
    d_sh    = $signed({{(IN_W-rspp_pkg::DEPTH_W-16){d_r[rspp_pkg::DEPTH_W-1]}}, d_r, 16'h0000});
    inner_x = d_sh + IN_W'(p_lat_r);
    inner_y = d_sh - IN_W'(p_h_r);
    mx      = inner_x * $signed({1'b0, screen_w_r});
    my      = inner_y * $signed({1'b0, screen_h_r});
    mw      = 44'(p_rw_r) * 44'(screen_w_r);
  end

  rspp_div_lane u_div_x (
    .clk(clk), .prep(cmd.prep), .step(cmd.step), .num(num_x_r),
    .den(d_r[rspp_pkg::DEN_W-1:0]), .neg(neg_x), .mag(mag_x)
  );
  rspp_div_lane u_div_y (
    .clk(clk), .prep(cmd.prep), .step(cmd.step), .num(num_y_r),
    .den(d_r[rspp_pkg::DEN_W-1:0]), .neg(neg_y), .mag(mag_y)
  );
  rspp_div_lane u_div_w (
    .clk(clk), .prep(cmd.prep), .step(cmd.step), .num(num_w_r),
    .den(d_r[rspp_pkg::DEN_W-1:0]), .neg(neg_w), .mag(mag_w)
  );

  always_comb begin
    // camera at or past the segment: hidden line at the screen bottom
    d_pos = !d_r[rspp_pkg::DEPTH_W-1] && (d_r != '0);
    x_fin = d_pos ? rspp_pkg::sat_s16(neg_x, mag_x) : {5'b0, screen_w_r[11:1]};
    y_fin = d_pos ? rspp_pkg::sat_s16(neg_y, mag_y) : {4'b0, screen_h_r};
    if (!d_pos || neg_w) w_fin = 16'h0000;
    else w_fin = mag_w[rspp_pkg::QBITS-1:16] != '0 ? 16'hFFFF : mag_w[15:0];
    draw  = $signed(y_fin) < horizon_r;
  end

  always_comb begin
    // hidden result carries zeros
    out_nxt = '0;
    if (draw) begin
      out_nxt.draw              = 1'b1;
      out_nxt.stripe            = stripe_r;
      out_nxt.near_y            = last_y_r;
      out_nxt.near_x            = last_x_r;
      out_nxt.near_half_width   = last_hw_r;
      out_nxt.near_rumble_width = rspp_pkg::rumble_width(last_hw_r);
      out_nxt.far_y             = y_fin;
      out_nxt.far_x             = x_fin;
      out_nxt.far_half_width    = w_fin;
      out_nxt.far_rumble_width  = rspp_pkg::rumble_width(w_fin);
    end
  end

  // configuration and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_depth_r   <= rspp_pkg::CAMERA_DEPTH_RST;
      road_width_r  <= rspp_pkg::ROAD_WIDTH_RST;
      screen_w_r    <= rspp_pkg::SCREEN_WIDTH_RST;
      screen_h_r    <= rspp_pkg::SCREEN_HEIGHT_RST;
      curve_off_r   <= '0;
      curve_slope_r <= '0;
      horizon_r     <= $signed({4'b0, rspp_pkg::SCREEN_HEIGHT_RST});
      last_x_r      <= {5'b0, rspp_pkg::SCREEN_WIDTH_RST[11:1]};
      last_y_r      <= {4'b0, rspp_pkg::SCREEN_HEIGHT_RST};
      last_hw_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          rspp_pkg::CFG_CAMERA_DEPTH:  cam_depth_r  <= cfg_wdata;
          rspp_pkg::CFG_ROAD_WIDTH:    road_width_r <= cfg_wdata;
          rspp_pkg::CFG_SCREEN_WIDTH:  screen_w_r   <= cfg_wdata[11:0];
          rspp_pkg::CFG_SCREEN_HEIGHT: screen_h_r   <= cfg_wdata[11:0];
          default: ;
        endcase
      end
      if (cmd.mul1) begin
        curve_off_r   <= off_nxt;
        curve_slope_r <= slope_nxt;
        if (in_r.first_of_frame) horizon_r <= $signed({4'b0, screen_h_r});
      end
      if (cmd.fin) begin
        if (draw) horizon_r <= $signed(y_fin);
        last_x_r    <= x_fin;
        last_y_r    <= y_fin;
        last_hw_r   <= w_fin;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_item;
      d_r  <= $signed({3'b000, in_item.seg_z}) - $signed({{2{in_item.cam_z[20]}}, in_item.cam_z});
    end
    if (cmd.mul1) begin
      p_lat_r  <= p_lat;
      p_h_r    <= p_h;
      p_rw_r   <= 32'(cam_depth_r) * 32'(road_width_r);
      stripe_r <= n_prod[rspp_pkg::RECIP3_SHIFT];
    end
    if (cmd.mul2) begin
      num_x_r <= rspp_pkg::NUM_W'(mx);
      num_y_r <= rspp_pkg::NUM_W'(my);
      num_w_r <= $signed({{(rspp_pkg::NUM_W-44){1'b0}}, mw});
    end
    if (cmd.fin) begin
      out_r <= out_nxt;
    end
  end

  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_item     = out_r;

endmodule

// ===== sv/rspp_ctrl.sv =====
// ----------------------------------------------------------------------------
// rspp_ctrl: projection sequencer
// Steps one segment through capture, products, numerators, divider setup,
// QBITS divider steps and the final stage, then returns to idle.
// ----------------------------------------------------------------------------
module rspp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rspp_pkg::dp_sts_t  sts,
  output rspp_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_MUL2 = 3'd2;
  localparam logic [2:0] ST_PREP = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  localparam int CNT_W = $clog2(rspp_pkg::QBITS);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = CNT_W'(rspp_pkg::QBITS - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == '0) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register can take the result
        if (!sts.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== sv/road_segment_projector_core.sv =====
// ----------------------------------------------------------------------------
// road_segment_projector_core: pseudo-3D road segment projection
// Projects one road segment per beat to a screen line and emits the
// trapezoid between the previous and the current line.
//
//   channel   direction  handshake          payload
//   in_ch     in         valid/ready        segment and camera fields
//   out_ch    out        valid/ready        draw, stripe, near and far lines
//   cfg_*     in         cfg_we, no ready   register index and data
//
// Between one accept and the next, when the result is drained, a segment passes
// through capture, two product stages, divider setup, 17 quotient steps of the
// three restoring divider lanes, and the final stage.
// A finished result waits in the output register; a new segment is accepted
// meanwhile, and the final stage of that one holds until the register frees.
// Synchronous active-low reset restores register defaults and frame state.
// ----------------------------------------------------------------------------
module road_segment_projector_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rspp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [rspp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  rspp_in_if.sink                           in_ch,
  rspp_out_if.source                        out_ch
);

  rspp_pkg::dp_cmd_t   cmd;
  rspp_pkg::dp_sts_t   sts;
  rspp_pkg::in_item_t  in_item;
  rspp_pkg::out_item_t out_item;
  logic                in_ready;
  logic                out_valid;

  assign in_item.first_of_frame = in_ch.first_of_frame;
  assign in_item.seg_number     = in_ch.seg_number;
  assign in_item.seg_z          = in_ch.seg_z;
  assign in_item.seg_y          = in_ch.seg_y;
  assign in_item.seg_curve      = in_ch.seg_curve;
  assign in_item.cam_x          = in_ch.cam_x;
  assign in_item.cam_y          = in_ch.cam_y;
  assign in_item.cam_z          = in_ch.cam_z;
  assign in_ch.ready            = in_ready;

  rspp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rspp_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign out_ch.valid             = out_valid;
  assign out_ch.draw              = out_item.draw;
  assign out_ch.stripe            = out_item.stripe;
  assign out_ch.near_y            = out_item.near_y;
  assign out_ch.near_x            = out_item.near_x;
  assign out_ch.near_half_width   = out_item.near_half_width;
  assign out_ch.near_rumble_width = out_item.near_rumble_width;
  assign out_ch.far_y             = out_item.far_y;
  assign out_ch.far_x             = out_item.far_x;
  assign out_ch.far_half_width    = out_item.far_half_width;
  assign out_ch.far_rumble_width  = out_item.far_rumble_width;

endmodule
